@@ rtl/scov_pkg.sv @@
// Shared constants, payload types and state codes of the spatial covariance accumulator.
package scov_pkg;

	localparam int FFT_SIZE = 512;
	localparam int CHANNELS = 4;
	localparam int NBINS    = FFT_SIZE / 2 + 1;
	localparam int ENTRIES  = 16;
	localparam int DEPTH    = NBINS * ENTRIES;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int BIN_W    = ADDR_W - 4;
	localparam int ACC_W    = 48;
	localparam int PROD_W   = 33;

	localparam logic [2:0]  CH_LIM     = 3'(CHANNELS);
	localparam logic [15:0] FRAMES_MAX = 16'hFFFF;

	typedef enum logic [0:0] {
		OP_ACC  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC,
		ST_DRAIN,
		ST_ACC_DONE,
		ST_READ,
		ST_RD_DONE
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [8:0]         bin;
		logic [3:0]         entry;
		logic               new_frame;
		logic signed [15:0] ch0_re;
		logic signed [15:0] ch0_im;
		logic signed [15:0] ch1_re;
		logic signed [15:0] ch1_im;
		logic signed [15:0] ch2_re;
		logic signed [15:0] ch2_im;
		logic signed [15:0] ch3_re;
		logic signed [15:0] ch3_im;
	} item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] sum_re;
		logic signed [ACC_W-1:0] sum_im;
		logic [15:0]             frames;
	} res_t;

	// Entry update issued towards the datapath
	typedef struct packed {
		logic              vld;
		logic              used;
		logic [3:0]        k;
		logic [ADDR_W-1:0] addr;
	} tag_t;

	// Store write port
	typedef struct packed {
		logic                    we;
		logic [ADDR_W-1:0]       addr;
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
	} wr_t;

endpackage

@@ rtl/scov_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module scov_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4112
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/scov_mac.sv @@
// Outer-product term and saturating read-modify-write datapath for one entry per cycle.
module scov_mac (
	input  logic                           clk,
	input  logic                           arst_n,
	input  scov_pkg::item_t                item,
	input  scov_pkg::tag_t                 tag,
	input  logic signed [scov_pkg::ACC_W-1:0] rdata_re,
	input  logic signed [scov_pkg::ACC_W-1:0] rdata_im,
	output scov_pkg::wr_t                  wr
);
	import scov_pkg::*;

	logic signed [15:0] xr [4];
	logic signed [15:0] xi [4];
	logic [1:0]         row;
	logic [1:0]         col;

	tag_t               tag_s1;
	logic signed [15:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [31:0] m_rr, m_ii, m_ir, m_ri;
	logic signed [PROD_W-1:0] pre, pim;

	tag_t                    tag_s2;
	logic signed [PROD_W-1:0] pre_s2, pim_s2;
	logic signed [ACC_W-1:0]  old_re_s2, old_im_s2;
	logic signed [ACC_W:0]    sum_re, sum_im;

	function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W:0] s);
		logic signed [ACC_W-1:0] r;
		case (s[ACC_W:ACC_W-1])
			2'b01:   r = {1'b0, {(ACC_W-1){1'b1}}};
			2'b10:   r = {1'b1, {(ACC_W-1){1'b0}}};
			default: r = s[ACC_W-1:0];
		endcase
		return r;
	endfunction

	always_comb begin
		xr[0] = item.ch0_re;
		xi[0] = item.ch0_im;
		xr[1] = item.ch1_re;
		xi[1] = item.ch1_im;
		xr[2] = item.ch2_re;
		xi[2] = item.ch2_im;
		xr[3] = item.ch3_re;
		xi[3] = item.ch3_im;
		row   = tag.k[3:2];
		col   = tag.k[1:0];
	end

	// Operand select alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		ar_s1 <= xr[row];
		ai_s1 <= xi[row];
		br_s1 <= xr[col];
		bi_s1 <= xi[col];
	end

	// x[r] * conj(x[c])
	always_comb begin
		m_rr = ar_s1 * br_s1;
		m_ii = ai_s1 * bi_s1;
		m_ir = ai_s1 * br_s1;
		m_ri = ar_s1 * bi_s1;
		pre  = PROD_W'(m_rr) + PROD_W'(m_ii);
		pim  = PROD_W'(m_ir) - PROD_W'(m_ri);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		pre_s2    <= pre;
		pim_s2    <= pim;
		old_re_s2 <= rdata_re;
		old_im_s2 <= rdata_im;
	end

	always_comb begin
		sum_re  = (ACC_W + 1)'(old_re_s2) + (ACC_W + 1)'(pre_s2);
		sum_im  = (ACC_W + 1)'(old_im_s2) + (ACC_W + 1)'(pim_s2);
		wr.we   = tag_s2.vld & tag_s2.used;
		wr.addr = tag_s2.addr;
		wr.re   = sat(sum_re);
		wr.im   = sat(sum_im);
	end

endmodule

@@ rtl/scov_seq.sv @@
// Command sequencer: clearing sweep, entry walk, frame counter and result register.
module scov_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  scov_pkg::item_t                   cmd,
	output logic                              busy,
	output logic                              done,
	output scov_pkg::res_t                    result,
	output scov_pkg::item_t                   item,
	output logic                              rd_en,
	output logic [scov_pkg::ADDR_W-1:0]       rd_addr,
	input  logic signed [scov_pkg::ACC_W-1:0] rdata_re,
	input  logic signed [scov_pkg::ACC_W-1:0] rdata_im,
	output scov_pkg::tag_t                    tag,
	output scov_pkg::wr_t                     clr
);
	import scov_pkg::*;

	state_t            state_q, state_d;
	item_t             item_q;
	logic [3:0]        k_q;
	logic [ADDR_W-1:0] clr_q;
	logic [15:0]       frames_q;
	res_t              res_q;
	logic              done_q;

	logic              accept;
	logic              cmd_bin_ok;
	logic              rd_ok;
	logic [BIN_W-1:0]  bin_idx;

	assign accept     = start && (state_q == ST_IDLE);
	assign cmd_bin_ok = (cmd.bin != 9'd0) && (32'(cmd.bin) < 32'(NBINS));
	assign rd_ok      = (32'(item_q.bin) < 32'(NBINS)) && ({1'b0, item_q.entry[3:2]} < CH_LIM)
		&& ({1'b0, item_q.entry[1:0]} < CH_LIM);
	assign bin_idx    = BIN_W'(item_q.bin);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (cmd.op == OP_READ) begin
						state_d = ST_READ;
					end else if (cmd_bin_ok) begin
						state_d = ST_ACC;
					end else begin
						state_d = ST_ACC_DONE;
					end
				end
			end
			ST_ACC: begin
				if (k_q == 4'hF) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:    state_d = ST_ACC_DONE;
			ST_ACC_DONE: state_d = ST_IDLE;
			ST_READ:     state_d = ST_RD_DONE;
			ST_RD_DONE:  state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q != ST_IDLE);
		rd_en    = (state_q == ST_ACC) || (state_q == ST_READ);
		rd_addr  = (state_q == ST_ACC) ? {bin_idx, k_q} : {bin_idx, item_q.entry};
		tag.vld  = (state_q == ST_ACC);
		tag.used = ({1'b0, k_q[3:2]} < CH_LIM) && ({1'b0, k_q[1:0]} < CH_LIM);
		tag.k    = k_q;
		tag.addr = {bin_idx, k_q};
		clr.we   = (state_q == ST_CLEAR);
		clr.addr = clr_q;
		clr.re   = '0;
		clr.im   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			k_q      <= '0;
			clr_q    <= '0;
			frames_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_ACC_DONE) || (state_q == ST_RD_DONE);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			// advance through the sixteen entries of the bin
			if (state_q == ST_ACC) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
			end
			if (accept && (cmd.op == OP_ACC) && cmd.new_frame && (frames_q != FRAMES_MAX)) begin
				frames_q <= frames_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
		if (state_q == ST_ACC_DONE) begin
			res_q.sum_re <= '0;
			res_q.sum_im <= '0;
			res_q.frames <= frames_q;
		end else if (state_q == ST_RD_DONE) begin
			res_q.sum_re <= rd_ok ? rdata_re : '0;
			res_q.sum_im <= rd_ok ? rdata_im : '0;
			res_q.frames <= frames_q;
		end
	end

	assign done   = done_q;
	assign result = res_q;
	assign item   = item_q;

endmodule

@@ rtl/spatial_covariance_accumulator.sv @@
// Spatial covariance accumulator: per-bin 4x4 complex outer-product sums held in block RAM.
//
// Command channel: present cmd with start high; the command transfers at a rising edge
// where start is high and busy is low. op = accumulate adds x * x^H of the four channel
// samples into the sixteen entries of the given bin (bin 0 and bins above FFT_SIZE/2
// are left alone); op = read returns one entry of one bin.
// Result channel: done is high for exactly one cycle with result valid; every command
// gives one result. Accumulate results carry zero sums and the frame count.
// On an accumulate to a valid bin the block walks one entry per cycle through a read,
// product and saturating write-back pipeline on the real and imaginary RAMs; busy drops
// on the same edge as done rises. Accumulates on ignored bins skip the entry walk, and
// reads return the entry through one RAM read port with registered read data.
// The block takes no new command until the current one has raised done.
// Reset: arst_n clears control state, then a clearing pass writes zero to all DEPTH
// (4112) entries, one per cycle, with busy high; the frame count starts at zero.
// The receiver cannot stall: a result must be taken in its done cycle.
module spatial_covariance_accumulator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  scov_pkg::item_t cmd,
	output logic            busy,
	output logic            done,
	output scov_pkg::res_t  result
);
	import scov_pkg::*;

	item_t                   item;
	tag_t                    tag;
	wr_t                     clr;
	wr_t                     mac_wr;
	wr_t                     wr;
	logic                    rd_en;
	logic [ADDR_W-1:0]       rd_addr;
	logic signed [ACC_W-1:0] rdata_re;
	logic signed [ACC_W-1:0] rdata_im;

	scov_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.item     (item),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rdata_re (rdata_re),
		.rdata_im (rdata_im),
		.tag      (tag),
		.clr      (clr)
	);

	scov_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.tag      (tag),
		.rdata_re (rdata_re),
		.rdata_im (rdata_im),
		.wr       (mac_wr)
	);

	// clearing pass and write-back never overlap
	assign wr = clr.we ? clr : mac_wr;

	scov_ram #(
		.WIDTH (ACC_W),
		.DEPTH (DEPTH)
	) u_ram_re (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.re),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata_re)
	);

	scov_ram #(
		.WIDTH (ACC_W),
		.DEPTH (DEPTH)
	) u_ram_im (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.im),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata_im)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after command transfer");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command in progress");

	a_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> busy)
		else $error("store written while idle");

	a_clear_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		clr.we |-> (!rd_en && !mac_wr.we))
		else $error("store access during clearing pass");
`endif

endmodule
